// ===== sv/sql_token_scanner_core_assert.svh =====
`ifndef SQL_TOKEN_SCANNER_CORE_ASSERT_SVH
`define SQL_TOKEN_SCANNER_CORE_ASSERT_SVH

// same-cycle implication, off while reset is held
`define SQLTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define SQLTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, also checked through reset
`define SQLTS_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/sqlts_pkg.sv =====
`default_nettype none

package sqlts_pkg;

    localparam int MAX_TEXT = 4096;
    localparam int POS_W    = $clog2(MAX_TEXT + 1);

    localparam int CH_W    = 8;
    localparam int KIND_W  = 5;
    localparam int START_W = 12;
    localparam int LEN_W   = 13;
    localparam int ERR_W   = 2;

    // result request data field layout
    localparam int OD_START_LSB = 0;
    localparam int OD_LEN_LSB   = OD_START_LSB + START_W;
    localparam int OD_ERR_LSB   = OD_LEN_LSB + LEN_W;
    localparam int OD_BAD_LSB   = OD_ERR_LSB + ERR_W;
    localparam int OD_FIN_BIT   = OD_BAD_LSB + CH_W;
    localparam int OD_USED_W    = OD_FIN_BIT + 1;
    localparam int OUT_DATA_W   = ((OD_USED_W + 7) / 8) * 8;

    localparam logic [KIND_W-1:0] K_END     = 5'd0;
    localparam logic [KIND_W-1:0] K_IDENT   = 5'd1;
    localparam logic [KIND_W-1:0] K_NUMBER  = 5'd2;
    localparam logic [KIND_W-1:0] K_STRING  = 5'd3;
    localparam logic [KIND_W-1:0] K_STAR    = 5'd4;
    localparam logic [KIND_W-1:0] K_COMMA   = 5'd5;
    localparam logic [KIND_W-1:0] K_DOT     = 5'd6;
    localparam logic [KIND_W-1:0] K_LPAREN  = 5'd7;
    localparam logic [KIND_W-1:0] K_RPAREN  = 5'd8;
    localparam logic [KIND_W-1:0] K_SEMI    = 5'd9;
    localparam logic [KIND_W-1:0] K_EQ      = 5'd10;
    localparam logic [KIND_W-1:0] K_NE      = 5'd11;
    localparam logic [KIND_W-1:0] K_GT      = 5'd12;
    localparam logic [KIND_W-1:0] K_GE      = 5'd13;
    localparam logic [KIND_W-1:0] K_LT      = 5'd14;
    localparam logic [KIND_W-1:0] K_LE      = 5'd15;
    localparam logic [KIND_W-1:0] K_KW_BASE = 5'd16;

    localparam logic [ERR_W-1:0] E_NONE    = 2'd0;
    localparam logic [ERR_W-1:0] E_BADCHAR = 2'd1;
    localparam logic [ERR_W-1:0] E_UNTERM  = 2'd2;
    localparam logic [ERR_W-1:0] E_TOOLONG = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   length;
        logic [ERR_W-1:0]   err;
        logic [CH_W-1:0]    bad;
        logic               fin;
        logic               last;
    } t_result;

    typedef struct packed {
        logic       fire;
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_batch;

endpackage

`default_nettype wire

// ===== sv/sql_token_scanner_core.sv =====
// channel   dir  tdata (lsb first)                                   tuser       tlast
// s_axis    in   ch[7:0]                                             -           end_of_text
// m_axis    out  start[11:0] length[24:12] error_code[26:25]          token_kind  last_of_run
//                bad_char[34:27] final_token[35] zero[39:36]
//
// one text byte per cycle unless m_axis stalls; a two-token item holds s_axis till both drain
// an s_axis request passes the input reg, then the result reg, on its way to m_axis
// the two-entry result register sets throughput, draining one result per cycle while tready
// i_rst_n is synchronous: clears the input stage, scanner state and pending results
// m_axis stalls back up through the result register to s_axis_tready

`default_nettype none

module sql_token_scanner_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [sqlts_pkg::CH_W-1:0]        s_axis_tdata,   // ch
    input  logic                              s_axis_tlast,

    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [sqlts_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // start, length, error_code,
                                                              // bad_char, final_token
    output logic [sqlts_pkg::KIND_W-1:0]      m_axis_tuser,   // token_kind
    output logic                              m_axis_tlast
);
    import sqlts_pkg::*;

    t_batch  batch;
    logic    can_load;
    t_result head;

    sqlts_step u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_ch       (s_axis_tdata),
        .i_eot      (s_axis_tlast),
        .i_can_load (can_load),
        .o_batch    (batch)
    );

    sqlts_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_batch    (batch),
        .i_ready    (m_axis_tready),
        .o_can_load (can_load),
        .o_valid    (m_axis_tvalid),
        .o_head     (head)
    );

    assign m_axis_tdata = {(OUT_DATA_W - OD_USED_W)'(0), head.fin, head.bad, head.err,
                           head.length, head.start};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;

endmodule

`default_nettype wire

// ===== sv/sqlts_step.sv =====
`default_nettype none

module sqlts_step (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [sqlts_pkg::CH_W-1:0] i_ch,
    input  logic                  i_eot,
    input  logic                  i_can_load,
    output sqlts_pkg::t_batch     o_batch
);
    import sqlts_pkg::*;

    localparam int KW_MAX = 7;
    localparam int KW_N   = 8;
    localparam int KB_W   = KW_MAX * 8;

    localparam logic [KB_W-1:0] KW_TEXT [KW_N] = '{
        {"INSERT", 8'h00}, {"INTO", 24'h0}, {"VALUES", 8'h00}, {"SELECT", 8'h00},
        {"FROM", 24'h0}, {"WHERE", 16'h0}, "BETWEEN", {"AND", 32'h0}
    };
    localparam logic [2:0] KW_LEN [KW_N] = '{
        3'd6, 3'd4, 3'd6, 3'd6, 3'd4, 3'd5, 3'd7, 3'd3
    };

    localparam logic [7:0] CH_STAR   = "*";
    localparam logic [7:0] CH_COMMA  = ",";
    localparam logic [7:0] CH_DOT    = ".";
    localparam logic [7:0] CH_LPAREN = "(";
    localparam logic [7:0] CH_RPAREN = ")";
    localparam logic [7:0] CH_SEMI   = ";";
    localparam logic [7:0] CH_EQ     = "=";
    localparam logic [7:0] CH_BANG   = "!";
    localparam logic [7:0] CH_GT     = ">";
    localparam logic [7:0] CH_LT     = "<";
    localparam logic [7:0] CH_QUOTE  = "'";
    localparam logic [7:0] CH_PLUS   = "+";
    localparam logic [7:0] CH_MINUS  = "-";
    localparam logic [7:0] CH_UNDER  = "_";
    localparam logic [7:0] CH_NUL    = 8'h00;

    typedef enum logic [2:0] {
        M_IDLE, M_IDENT, M_NUMBER, M_STRING, M_OPER, M_SIGN, M_DRAINED
    } t_mode;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic [7:0] upper(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) ? c - 8'd32 : c;
    endfunction

    function automatic t_result mk_tok(input logic [KIND_W-1:0] kind,
                                       input logic [POS_W-1:0] start,
                                       input logic [POS_W:0] len);
        t_result r;
        r        = '0;
        r.kind   = kind;
        r.start  = START_W'(start);
        r.length = LEN_W'(len);
        return r;
    endfunction

    function automatic t_result mk_err(input logic [ERR_W-1:0] code,
                                       input logic [7:0] bad);
        t_result r;
        r     = '0;
        r.err = code;
        r.bad = bad;
        r.fin = 1'b1;
        return r;
    endfunction

    function automatic t_result mk_end();
        t_result r;
        r     = '0;
        r.fin = 1'b1;
        return r;
    endfunction

    function automatic logic [KIND_W-1:0] ident_kind(input logic [KB_W-1:0] kb,
                                                     input logic [POS_W-1:0] len);
        logic [KIND_W-1:0] kind;
        logic [KB_W-1:0]   mask;
        kind = K_IDENT;
        if (len <= POS_W'(KW_MAX)) begin
            for (int k = KW_N - 1; k >= 0; k--) begin
                mask = ~({KB_W{1'b1}} >> (8 * KW_LEN[k]));
                if ((len == POS_W'(KW_LEN[k])) && (((kb ^ KW_TEXT[k]) & mask) == '0)) begin
                    kind = K_KW_BASE + KIND_W'(k);
                end
            end
        end
        return kind;
    endfunction

    logic                       r_in_valid;
    logic [CH_W-1:0]            r_ch;
    logic                       r_eot;
    t_mode                      r_mode, n_mode;
    logic [POS_W-1:0]           r_pos, n_pos;
    logic [POS_W-1:0]           r_tb, n_tb;
    logic [7:0]                 r_pend, n_pend;
    logic [0:KW_MAX-1][7:0]     r_kb, n_kb;

    logic                       fire;
    logic [POS_W-1:0]           tok_len;

    logic                       f_has, f_ok;
    t_result                    f_res, f_err;

    logic                       s_tok, s_err;
    logic [KIND_W-1:0]          s_kind;
    t_result                    s_res;
    t_mode                      s_mode;

    logic                       do_start, pre_has;
    logic [1:0]                 b_cnt;
    t_result                    b_r0, b_r1;

    assign fire       = r_in_valid && i_can_load;
    assign o_in_ready = !r_in_valid || fire;
    assign tok_len    = r_pos - r_tb;

    // token held open by the current mode
    always_comb begin
        f_has = 1'b0;
        f_ok  = 1'b1;
        f_res = '0;
        f_err = '0;
        unique case (r_mode)
            M_IDENT: begin
                f_has = 1'b1;
                f_res = mk_tok(ident_kind(r_kb, tok_len), r_tb, {1'b0, tok_len});
            end
            M_NUMBER: begin
                f_has = 1'b1;
                f_res = mk_tok(K_NUMBER, r_tb, {1'b0, tok_len});
            end
            M_OPER: begin
                if (r_pend == CH_BANG) begin
                    f_ok  = 1'b0;
                    f_err = mk_err(E_BADCHAR, CH_BANG);
                end else begin
                    f_has = 1'b1;
                    f_res = mk_tok((r_pend == CH_GT) ? K_GT : K_LT, r_tb, (POS_W + 1)'(1));
                end
            end
            M_SIGN: begin
                f_ok  = 1'b0;
                f_err = mk_err(E_BADCHAR, r_pend);
            end
            M_STRING: begin
                f_ok  = 1'b0;
                f_err = mk_err(E_UNTERM, 8'h00);
            end
            default: ;
        endcase
    end

    // what the current byte opens when seen between tokens
    always_comb begin
        s_tok  = 1'b0;
        s_err  = 1'b0;
        s_kind = K_END;
        s_mode = M_IDLE;
        unique case (r_ch) inside
            CH_STAR: begin
                s_tok  = 1'b1;
                s_kind = K_STAR;
            end
            CH_COMMA: begin
                s_tok  = 1'b1;
                s_kind = K_COMMA;
            end
            CH_DOT: begin
                s_tok  = 1'b1;
                s_kind = K_DOT;
            end
            CH_LPAREN: begin
                s_tok  = 1'b1;
                s_kind = K_LPAREN;
            end
            CH_RPAREN: begin
                s_tok  = 1'b1;
                s_kind = K_RPAREN;
            end
            CH_SEMI: begin
                s_tok  = 1'b1;
                s_kind = K_SEMI;
            end
            CH_EQ: begin
                s_tok  = 1'b1;
                s_kind = K_EQ;
            end
            CH_BANG, CH_GT, CH_LT: begin
                s_mode = M_OPER;
            end
            CH_QUOTE: begin
                s_mode = M_STRING;
            end
            CH_PLUS, CH_MINUS: begin
                s_mode = M_SIGN;
            end
            default: begin
                if (is_digit(r_ch)) begin
                    s_mode = M_NUMBER;
                end else if (is_alpha(r_ch) || (r_ch == CH_UNDER)) begin
                    s_mode = M_IDENT;
                end else if (!is_space(r_ch)) begin
                    s_err = 1'b1;
                end
            end
        endcase
        s_res = mk_tok(s_kind, r_pos, (POS_W + 1)'(1));
    end

    // next state and results of the held request
    always_comb begin
        n_mode   = r_mode;
        n_pos    = r_pos;
        n_tb     = r_tb;
        n_pend   = r_pend;
        n_kb     = r_kb;
        b_cnt    = 2'd0;
        b_r0     = '0;
        b_r1     = '0;
        do_start = 1'b0;
        pre_has  = 1'b0;

        if (r_eot || (r_ch == CH_NUL)) begin
            if (r_mode != M_DRAINED) begin
                if (!f_ok) begin
                    b_r0  = f_err;
                    b_cnt = 2'd1;
                end else if (f_has) begin
                    b_r0  = f_res;
                    b_r1  = mk_end();
                    b_cnt = 2'd2;
                end else begin
                    b_r0  = mk_end();
                    b_cnt = 2'd1;
                end
            end
            if (r_eot) begin
                n_mode = M_IDLE;
                n_pos  = '0;
                n_tb   = '0;
                n_pend = '0;
                n_kb   = '0;
            end else begin
                n_mode = M_DRAINED;
            end
        end else if (r_mode == M_DRAINED) begin
            n_mode = M_DRAINED;
        end else if (r_pos >= POS_W'(MAX_TEXT)) begin
            b_r0   = mk_err(E_TOOLONG, 8'h00);
            b_cnt  = 2'd1;
            n_mode = M_DRAINED;
        end else begin
            unique case (r_mode)
                M_OPER: begin
                    if (r_ch == CH_EQ) begin
                        b_r0   = mk_tok((r_pend == CH_BANG) ? K_NE :
                                        ((r_pend == CH_GT) ? K_GE : K_LE),
                                        r_tb, (POS_W + 1)'(2));
                        b_cnt  = 2'd1;
                        n_mode = M_IDLE;
                    end else if (!f_ok) begin
                        b_r0   = f_err;
                        b_cnt  = 2'd1;
                        n_mode = M_DRAINED;
                    end else begin
                        pre_has  = 1'b1;
                        do_start = 1'b1;
                    end
                end
                M_SIGN: begin
                    if (is_digit(r_ch)) begin
                        n_mode = M_NUMBER;
                    end else begin
                        b_r0   = mk_err(E_BADCHAR, r_pend);
                        b_cnt  = 2'd1;
                        n_mode = M_DRAINED;
                    end
                end
                M_NUMBER: begin
                    if (!is_digit(r_ch)) begin
                        pre_has  = 1'b1;
                        do_start = 1'b1;
                    end
                end
                M_IDENT: begin
                    if (is_word(r_ch)) begin
                        if (tok_len < POS_W'(KW_MAX)) begin
                            n_kb[tok_len[2:0]] = upper(r_ch);
                        end
                    end else begin
                        pre_has  = 1'b1;
                        do_start = 1'b1;
                    end
                end
                M_STRING: begin
                    if (r_ch == CH_QUOTE) begin
                        b_r0   = mk_tok(K_STRING, r_tb, {1'b0, tok_len} + 1'b1);
                        b_cnt  = 2'd1;
                        n_mode = M_IDLE;
                    end
                end
                M_IDLE: begin
                    do_start = 1'b1;
                end
                default: ;
            endcase

            if (do_start) begin
                if (s_err) begin
                    b_r0   = mk_err(E_BADCHAR, r_ch);
                    b_cnt  = 2'd1;
                    n_mode = M_DRAINED;
                end else begin
                    n_mode = s_mode;
                    if (!s_tok) begin
                        n_tb = r_pos;
                    end
                    if ((s_mode == M_OPER) || (s_mode == M_SIGN)) begin
                        n_pend = r_ch;
                    end
                    if (s_mode == M_IDENT) begin
                        n_kb[0] = upper(r_ch);
                    end
                    if (pre_has) begin
                        b_r0  = f_res;
                        b_r1  = s_res;
                        b_cnt = s_tok ? 2'd2 : 2'd1;
                    end else if (s_tok) begin
                        b_r0  = s_res;
                        b_cnt = 2'd1;
                    end
                end
            end

            if (n_mode != M_DRAINED) begin
                n_pos = r_pos + 1'b1;
            end
        end

        if (b_cnt == 2'd2) begin
            b_r1.last = 1'b1;
        end else if (b_cnt == 2'd1) begin
            b_r0.last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_ch       <= '0;
            r_eot      <= 1'b0;
            r_mode     <= M_IDLE;
            r_pos      <= '0;
            r_tb       <= '0;
            r_pend     <= '0;
            r_kb       <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
                r_ch       <= i_ch;
                r_eot      <= i_eot;
            end
            if (fire) begin
                r_mode <= n_mode;
                r_pos  <= n_pos;
                r_tb   <= n_tb;
                r_pend <= n_pend;
                r_kb   <= n_kb;
            end
        end
    end

    assign o_batch.fire = fire;
    assign o_batch.cnt  = b_cnt;
    assign o_batch.r0   = b_r0;
    assign o_batch.r1   = b_r1;

endmodule

`default_nettype wire

// ===== sv/sqlts_outbuf.sv =====
`default_nettype none

module sqlts_outbuf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sqlts_pkg::t_batch    i_batch,
    input  logic                 i_ready,
    output logic                 o_can_load,
    output logic                 o_valid,
    output sqlts_pkg::t_result   o_head
);
    import sqlts_pkg::*;

    logic [1:0] r_cnt;
    t_result    r_ent0, r_ent1;
    logic       pop;

    assign pop        = (r_cnt != 2'd0) && i_ready;
    assign o_can_load = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop);
    assign o_valid    = (r_cnt != 2'd0);
    assign o_head     = r_ent0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_batch.fire) begin
            r_cnt <= i_batch.cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // result payload, second entry slides forward on a pop
    always_ff @(posedge i_clk) begin
        if (i_batch.fire) begin
            r_ent0 <= i_batch.r0;
            r_ent1 <= i_batch.r1;
        end else if (pop) begin
            r_ent0 <= r_ent1;
        end
    end

endmodule

`default_nettype wire

// ===== sv/sqlts_checker.sv =====
`default_nettype none

`include "sql_token_scanner_core_assert.svh"

module sqlts_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [sqlts_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic [sqlts_pkg::KIND_W-1:0]      m_axis_tuser,
    input  logic                              m_axis_tlast
);
    import sqlts_pkg::*;

    logic [ERR_W-1:0]   o_err;
    logic [START_W-1:0] o_start;
    logic [LEN_W-1:0]   o_len;
    logic               o_fin;

    assign o_err   = m_axis_tdata[OD_ERR_LSB +: ERR_W];
    assign o_start = m_axis_tdata[OD_START_LSB +: START_W];
    assign o_len   = m_axis_tdata[OD_LEN_LSB +: LEN_W];
    assign o_fin   = m_axis_tdata[OD_FIN_BIT];

    `SQLTS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result changed while stalled")
    `SQLTS_ASSERT_IMP(a_err_alone, i_clk, i_rst_n, m_axis_tvalid && (o_err != E_NONE), o_fin && m_axis_tlast && (m_axis_tuser == K_END), "error result not final and alone")
    `SQLTS_ASSERT_IMP(a_final_empty, i_clk, i_rst_n, m_axis_tvalid && o_fin, (o_start == '0) && (o_len == '0) && m_axis_tlast, "final result carries a token span")
    `SQLTS_ASSERT_NXT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n, !m_axis_tvalid, "result shown right after reset")

endmodule

bind sql_token_scanner_core sqlts_checker u_sqlts_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== tb/sv/tb_sql_token_scanner_core.sv =====
module tb_sql_token_scanner_core;
    import sqlts_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef enum logic [2:0] {
        LX_IDLE, LX_IDENT, LX_NUMBER, LX_STRING, LX_OPER, LX_SIGN, LX_DRAINED
    } t_lex_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [CH_W-1:0]       s_axis_tdata;   // ch
    logic                  s_axis_tlast;   // end_of_text

    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // start, length, error_code, bad_char,
                                           // final_token, zero pad
    logic [KIND_W-1:0]     m_axis_tuser;   // token_kind
    logic                  m_axis_tlast;   // last_of_run

    sql_token_scanner_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    string kw_word [8] = '{"INSERT", "INTO", "VALUES", "SELECT",
                           "FROM", "WHERE", "BETWEEN", "AND"};

    // scanner copy
    t_lex_mode         scan_state;
    logic [POS_W-1:0]  text_pos;
    logic [START_W-1:0] tok_begin;
    logic [CH_W-1:0]   held_char;
    logic [CH_W-1:0]   word_buf [7];

    t_result           step_tokens [$];
    t_result           token_q [$];
    logic [CH_W-1:0]   line_buf [$];

    int  mismatches  = 0;
    int  items_sent  = 0;
    int  cycle_count = 0;
    int  hold_cycles = 0;
    bit  idle_on     = 1'b1;

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit is_space(logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [7:0] to_upper(logic [7:0] c);
        return (c >= "a" && c <= "z") ? c - 8'd32 : c;
    endfunction

    function automatic void scanner_clear();
        scan_state = LX_IDLE;
        text_pos   = '0;
        tok_begin  = '0;
        held_char  = '0;
        foreach (word_buf[i]) word_buf[i] = '0;
    endfunction

    function automatic logic [KIND_W-1:0] word_kind(logic [LEN_W-1:0] len);
        bit same;
        if (len > 7) return K_IDENT;
        for (int k = 0; k < 8; k++) begin
            if (kw_word[k].len() != len) continue;
            same = 1'b1;
            for (int i = 0; i < len; i++)
                if (word_buf[i] != kw_word[k][i]) same = 1'b0;
            if (same) return K_KW_BASE + KIND_W'(k);
        end
        return K_IDENT;
    endfunction

    function automatic void push_tok(logic [KIND_W-1:0] kind, logic [START_W-1:0] start,
                                     logic [LEN_W-1:0] len);
        t_result r;
        r = '0;
        r.kind   = kind;
        r.start  = start;
        r.length = len;
        step_tokens.push_back(r);
    endfunction

    function automatic void push_end();
        t_result r;
        r = '0;
        r.kind = K_END;
        r.fin  = 1'b1;
        step_tokens.push_back(r);
    endfunction

    // an error result replaces anything the same byte produced
    function automatic void push_err(logic [ERR_W-1:0] code, logic [CH_W-1:0] bad);
        t_result r;
        r = '0;
        r.kind = K_END;
        r.err  = code;
        r.bad  = bad;
        r.fin  = 1'b1;
        step_tokens.delete();
        step_tokens.push_back(r);
        scan_state = LX_DRAINED;
    endfunction

    function automatic bit close_token();
        logic [LEN_W-1:0] len;
        len = text_pos - {1'b0, tok_begin};
        case (scan_state)
            LX_IDENT:  push_tok(word_kind(len), tok_begin, len);
            LX_NUMBER: push_tok(K_NUMBER, tok_begin, len);
            LX_OPER: begin
                if (held_char == "!") begin
                    push_err(E_BADCHAR, "!");
                    return 1'b0;
                end
                push_tok(held_char == ">" ? K_GT : K_LT, tok_begin, LEN_W'(1));
            end
            LX_SIGN: begin
                push_err(E_BADCHAR, held_char);
                return 1'b0;
            end
            LX_STRING: begin
                push_err(E_UNTERM, '0);
                return 1'b0;
            end
            default: ;
        endcase
        scan_state = LX_IDLE;
        return 1'b1;
    endfunction

    function automatic void open_token(logic [7:0] c);
        logic [KIND_W-1:0] kind;
        bit                one_char;
        one_char = 1'b1;
        case (c)
            "*":     kind = K_STAR;
            ",":     kind = K_COMMA;
            ".":     kind = K_DOT;
            "(":     kind = K_LPAREN;
            ")":     kind = K_RPAREN;
            ";":     kind = K_SEMI;
            "=":     kind = K_EQ;
            default: begin
                kind     = K_END;
                one_char = 1'b0;
            end
        endcase
        if (one_char) begin
            push_tok(kind, text_pos[START_W-1:0], LEN_W'(1));
            return;
        end
        tok_begin = text_pos[START_W-1:0];
        if (c == "!" || c == ">" || c == "<") begin
            scan_state = LX_OPER;
            held_char  = c;
        end else if (c == "'") begin
            scan_state = LX_STRING;
        end else if (is_digit(c)) begin
            scan_state = LX_NUMBER;
        end else if (c == "+" || c == "-") begin
            scan_state = LX_SIGN;
            held_char  = c;
        end else if (is_alpha(c) || c == "_") begin
            scan_state  = LX_IDENT;
            word_buf[0] = to_upper(c);
        end else if (!is_space(c)) begin
            push_err(E_BADCHAR, c);
        end
    endfunction

    function automatic void scan_item(logic [7:0] c, logic eot);
        logic [LEN_W-1:0] len;
        bit               done;
        step_tokens.delete();
        if (eot) begin
            if (scan_state != LX_DRAINED && close_token()) push_end();
            scanner_clear();
        end else if (scan_state == LX_DRAINED) begin
            // dropped until the end item
        end else if (c == 8'd0) begin
            if (close_token()) push_end();
            scan_state = LX_DRAINED;
        end else if (text_pos >= MAX_TEXT) begin
            push_err(E_TOOLONG, '0);
        end else begin
            done = 1'b0;
            len  = text_pos - {1'b0, tok_begin};
            case (scan_state)
                LX_OPER: begin
                    if (c == "=") begin
                        push_tok(held_char == "!" ? K_NE : (held_char == ">" ? K_GE : K_LE),
                                 tok_begin, LEN_W'(2));
                        scan_state = LX_IDLE;
                        done = 1'b1;
                    end else if (!close_token()) begin
                        done = 1'b1;
                    end
                end
                LX_SIGN: begin
                    if (!is_digit(c)) push_err(E_BADCHAR, held_char);
                    else scan_state = LX_NUMBER;
                    done = 1'b1;
                end
                LX_NUMBER: begin
                    if (is_digit(c)) done = 1'b1;
                    else void'(close_token());
                end
                LX_IDENT: begin
                    if (is_alpha(c) || is_digit(c) || c == "_") begin
                        if (len < 7) word_buf[len[2:0]] = to_upper(c);
                        done = 1'b1;
                    end else begin
                        void'(close_token());
                    end
                end
                LX_STRING: begin
                    if (c == "'") begin
                        push_tok(K_STRING, tok_begin, LEN_W'(len + 1));
                        scan_state = LX_IDLE;
                    end
                    done = 1'b1;
                end
                default: ;
            endcase
            if (!done) open_token(c);
            if (scan_state != LX_DRAINED) text_pos++;
        end
        if (step_tokens.size() > 0) step_tokens[$].last = 1'b1;
        foreach (step_tokens[i]) token_q.push_back(step_tokens[i]);
    endfunction

    // request driver
    task automatic send_item(input logic [7:0] c, input logic eot);
        int gap;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= eot;
        do @(posedge i_clk); while (!s_axis_tready);
        scan_item(c, eot);
        items_sent++;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 6);
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_line(input bit with_end);
        foreach (line_buf[i]) send_item(line_buf[i], 1'b0);
        line_buf.delete();
        if (with_end) send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_stmt(input string s);
        foreach (s[i]) line_buf.push_back(s[i]);
        send_line(1'b1);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (token_q.size() > 0) @(posedge i_clk);
    endtask

    function automatic void add_word(string w, bit mixcase);
        logic [7:0] b;
        foreach (w[i]) begin
            b = w[i];
            if (mixcase && b >= "A" && b <= "Z" && $urandom_range(0, 1)) b = b + 8'd32;
            line_buf.push_back(b);
        end
    endfunction

    function automatic void add_pick(string choices);
        line_buf.push_back(choices[$urandom_range(0, choices.len() - 1)]);
    endfunction

    function automatic logic [7:0] rand_word_char();
        case ($urandom_range(0, 3))
            0:       return 8'("A" + $urandom_range(0, 25));
            1:       return 8'("a" + $urandom_range(0, 25));
            2:       return 8'("0" + $urandom_range(0, 9));
            default: return "_";
        endcase
    endfunction

    function automatic void add_lexeme();
        int         n;
        logic [7:0] b;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                add_word(kw_word[$urandom_range(0, 7)], 1'b1);
                if ($urandom_range(0, 5) == 0) line_buf.push_back(rand_word_char());
            end
            3: begin
                line_buf.push_back($urandom_range(0, 4) == 0 ? 8'("_") :
                                   8'("a" + $urandom_range(0, 25)));
                n = $urandom_range(0, 10);
                repeat (n) line_buf.push_back(rand_word_char());
            end
            4: begin
                if ($urandom_range(0, 2) == 0) add_pick("+-");
                n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
                repeat (n) line_buf.push_back(8'("0" + $urandom_range(0, 9)));
            end
            5: begin
                line_buf.push_back("'");
                n = $urandom_range(0, 8);
                repeat (n) begin
                    do b = 8'($urandom_range(1, 255)); while (b == "'");
                    line_buf.push_back(b);
                end
                if ($urandom_range(0, 9) != 0) line_buf.push_back("'");
            end
            6: add_pick("*,.();=");
            7: begin
                case ($urandom_range(0, 5))
                    0:       add_word("!=", 1'b0);
                    1:       add_word(">=", 1'b0);
                    2:       add_word("<=", 1'b0);
                    3:       add_word(">", 1'b0);
                    4:       add_word("<", 1'b0);
                    default: add_word("!", 1'b0);
                endcase
            end
            8: begin
                case ($urandom_range(0, 5))
                    0:       add_word("IN", 1'b1);
                    1:       add_word("INS", 1'b1);
                    2:       add_word("INTOX", 1'b1);
                    3:       add_word("BETWEE", 1'b1);
                    4:       add_word("WHEREAS", 1'b1);
                    default: add_word("AN", 1'b1);
                endcase
            end
            default: begin
                if ($urandom_range(0, 3) == 0) line_buf.push_back(8'($urandom_range(1, 255)));
                else line_buf.push_back(" ");
            end
        endcase
        n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 2);
        repeat (n) line_buf.push_back($urandom_range(0, 1) ? 8'(" ") :
                                      8'($urandom_range(9, 13)));
    endfunction

    task automatic send_random_stmt();
        int n;
        n = $urandom_range(3, 12);
        repeat (n) add_lexeme();
        if ($urandom_range(0, 9) == 0) begin
            send_line(1'b0);
            send_item(8'd0, 1'b0);
            n = $urandom_range(0, 3);
            repeat (n) send_item(8'($urandom_range(0, 255)), 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1);
        end else begin
            send_line(1'b1);
        end
    endtask

    // tests
    task automatic test_single_tokens();
        send_stmt("*,.();=!=>=<=><");
        send_stmt("Select from_x INTO Between and3 'it''s' +12 -7 values WHERE insert");
        send_item(8'hFF, 1'b1);
        wait_drained();
    endtask

    task automatic test_error_cases();
        send_stmt("a!b");
        send_stmt("-x");
        send_stmt("'ab");
        send_stmt("12#");
        send_stmt("a>!");
        line_buf.push_back(8'hFF);
        send_line(1'b1);
        add_word("x(", 1'b0);
        send_line(1'b0);
        send_item(8'd0, 1'b0);
        send_item("z", 1'b0);
        send_item(8'd0, 1'b0);
        send_item(8'h80, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_text();
        int goal;
        goal = items_sent + 640;
        while (items_sent < goal) begin
            send_random_stmt();
            if ($urandom_range(0, 15) == 0) wait_drained();
        end
        wait_drained();
    endtask

    task automatic test_output_stall();
        hold_cycles = 200;
        repeat (4) send_random_stmt();
        wait_drained();
    endtask

    task automatic test_full_rate();
        int goal;
        idle_on = 1'b0;
        goal = items_sent + 200;
        while (items_sent < goal) send_random_stmt();
        wait_drained();
    endtask

    // result sink ready
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                hold_cycles--;
            end else if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                stall_left = $urandom_range(0, 5);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (token_q.size() == 0) begin
                $error("result with none expected: kind %0d", m_axis_tuser);
                mismatches++;
            end else begin
                want = token_q.pop_front();
                check_field("token_kind", want.kind, m_axis_tuser);
                check_field("token_start", want.start, m_axis_tdata[OD_START_LSB +: START_W]);
                check_field("token_length", want.length, m_axis_tdata[OD_LEN_LSB +: LEN_W]);
                check_field("error_code", want.err, m_axis_tdata[OD_ERR_LSB +: ERR_W]);
                check_field("bad_char", want.bad, m_axis_tdata[OD_BAD_LSB +: CH_W]);
                check_field("final_token", want.fin, m_axis_tdata[OD_FIN_BIT]);
                check_field("last_of_run", want.last, m_axis_tlast);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        scanner_clear();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_single_tokens();
        test_error_cases();
        test_random_text();
        test_output_stall();
        test_full_rate();

        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== sql_token_scanner_core.f =====
+incdir+sv
sv/sqlts_pkg.sv
sv/sqlts_step.sv
sv/sqlts_outbuf.sv
sv/sql_token_scanner_core.sv
sv/sqlts_checker.sv
tb/sv/tb_sql_token_scanner_core.sv
